// ===== hdl/range_lock_table_macros.svh =====
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef RANGE_LOCK_TABLE_MACROS_SVH
`define RANGE_LOCK_TABLE_MACROS_SVH

// same-cycle implication
`define RLT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rlt_pkg.sv =====
`default_nettype none

package rlt_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned START_W     = 63;
  localparam int unsigned LEN_W       = 32;
  localparam int unsigned TXN_W       = 31;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned LAST_W      = 64;

  typedef enum logic [1:0] {
    REQ_LOCK     = 2'd0,
    REQ_RELEASE  = 2'd1,
    REQ_QUERY    = 2'd2,
    REQ_ROLLBACK = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    req_t               req_type;
    logic [START_W-1:0] range_start;
    logic [LEN_W-1:0]   range_length;
    logic [TXN_W-1:0]   txn_id;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 overlap_found;
    logic [CNT_OUT_W-1:0] cleared_count;
    logic [CNT_OUT_W-1:0] occupancy;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic [TXN_W-1:0]   owner;
    logic [LEN_W-1:0]   length;
    logic [START_W-1:0] start;
  } slot_t;

  typedef struct packed {
    logic occupied;
    logic overlap;
    logic owner_eq;
  } hit_t;

endpackage

`default_nettype wire

// ===== hdl/rlt_mem.sv =====
`default_nettype none

module rlt_mem import rlt_pkg::*; #(
  parameter int unsigned DEPTH = ENTRIES_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire slot_t         wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output slot_t              rd_data
);

  slot_t mem [DEPTH];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/rlt_match.sv =====
`default_nettype none

module rlt_match import rlt_pkg::*; (
  input  wire slot_t              entry,
  input  wire logic [START_W-1:0] req_start,
  input  wire logic [LAST_W-1:0]  req_last,
  input  wire logic [TXN_W-1:0]   req_txn,
  output hit_t                    hit
);

  logic [LAST_W-1:0] entry_first;
  logic [LAST_W-1:0] entry_last;

  // inclusive end, 64 bits so it never wraps
  assign entry_first = {1'b0, entry.start};
  assign entry_last  = entry_first + {{(LAST_W-LEN_W){1'b0}}, entry.length} - LAST_W'(1);

  assign hit.occupied = entry.valid;
  assign hit.overlap  = ({1'b0, req_start} <= entry_last) && (entry_first <= req_last);
  assign hit.owner_eq = (entry.owner == req_txn);

endmodule

`default_nettype wire

// ===== hdl/range_lock_table.sv =====
// channel  ports                          transaction
// in       in_valid, in_stall, in_data    one request (lock, release, query, rollback)
// out      out_valid, out_stall, out_data one result per request
//
// a request scans the entry memory one entry per cycle, a rate
// set by the single read port of the memory; lock stops at the first free entry
// zero-length requests (rollback apart) and locks on a full table finish without a scan
// after reset a clearing pass over every entry holds in_stall high
// a new request is taken while the previous result still waits on out_stall
`default_nettype none

module range_lock_table import rlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = ENTRIES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  `include "range_lock_table_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

  fsm_t              state_r, state_nxt;
  in_item_t          req_r;
  logic [LAST_W-1:0] req_last_r;
  status_t           status_r;
  logic              found_r;
  logic [CW-1:0]     cleared_r;
  logic [CW-1:0]     used_r;
  logic [AW-1:0]     rd_idx_r;
  logic              issuing_r;
  logic              pend_r;
  logic [AW-1:0]     pend_idx_r;
  logic [AW-1:0]     clr_idx_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic    accept;
  logic    out_load;
  logic    rd_en;
  logic    wr_en;
  logic [AW-1:0] wr_addr;
  slot_t   wr_data;
  slot_t   rd_data;
  hit_t    hit;
  logic    lock_hit;
  logic    clear_now;
  logic    query_hit;
  logic    finish;
  logic    zero_len;
  status_t pre_status;

  rlt_mem #(
    .DEPTH (TABLE_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  rlt_match u_match (
    .entry     (rd_data),
    .req_start (req_r.range_start),
    .req_last  (req_last_r),
    .req_txn   (req_r.txn_id),
    .hit       (hit)
  );

  assign accept   = in_valid && !in_stall;
  assign zero_len = (in_data.range_length == '0) && (in_data.req_type != REQ_ROLLBACK);

  always_comb begin
    priority if (zero_len) begin
      pre_status = STAT_ZERO;
    end else if ((in_data.req_type == REQ_LOCK) && (used_r == FULL_CNT)) begin
      pre_status = STAT_FULL;
    end else begin
      pre_status = STAT_OK;
    end
  end

  assign lock_hit  = pend_r && (req_r.req_type == REQ_LOCK) && !hit.occupied;
  assign clear_now = pend_r && hit.occupied &&
                     (((req_r.req_type == REQ_RELEASE) && hit.overlap) ||
                      ((req_r.req_type == REQ_ROLLBACK) && hit.owner_eq));
  assign query_hit = pend_r && hit.occupied && hit.overlap && (req_r.req_type == REQ_QUERY);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_CLEAR: begin
        if (clr_idx_r == LAST_IDX) state_nxt = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (accept) state_nxt = (pre_status == STAT_OK) ? FSM_SCAN : FSM_DONE;
      end
      FSM_SCAN: begin
        if (finish) state_nxt = FSM_DONE;
      end
      FSM_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = pend_idx_r;
    wr_data  = rd_data;
    finish   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      FSM_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = '0;
      end
      FSM_IDLE: begin
        in_stall = 1'b0;
      end
      FSM_SCAN: begin
        rd_en  = issuing_r;
        finish = lock_hit || (pend_r && (pend_idx_r == LAST_IDX));
        if (lock_hit) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b1;
          wr_data.owner = req_r.txn_id;
          wr_data.length = req_r.range_length;
          wr_data.start = req_r.range_start;
        end else if (clear_now) begin
          wr_en         = 1'b1;
          wr_data.valid = 1'b0;
        end
      end
      FSM_DONE: begin
        out_load = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_CLEAR;
      clr_idx_r   <= '0;
      used_r      <= '0;
      issuing_r   <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == FSM_CLEAR) clr_idx_r <= clr_idx_r + AW'(1);
      if (accept) begin
        issuing_r <= 1'b1;
      end else if (rd_en && (rd_idx_r == LAST_IDX)) begin
        issuing_r <= 1'b0;
      end else if (finish) begin
        issuing_r <= 1'b0;
      end
      pend_r <= rd_en && !finish;
      if (finish) begin
        if (lock_hit) begin
          used_r <= used_r + CW'(1);
        end else begin
          used_r <= used_r - cleared_r - CW'(clear_now);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= rd_idx_r;
    if (accept) begin
      req_r      <= in_data;
      req_last_r <= {1'b0, in_data.range_start} +
                    {{(LAST_W-LEN_W){1'b0}}, in_data.range_length} - LAST_W'(1);
      status_r   <= pre_status;
      found_r    <= 1'b0;
      cleared_r  <= '0;
      rd_idx_r   <= '0;
    end else begin
      if (rd_en && (rd_idx_r != LAST_IDX)) rd_idx_r <= rd_idx_r + AW'(1);
      if (clear_now) cleared_r <= cleared_r + CW'(1);
      if (query_hit) found_r <= 1'b1;
      if (finish && (req_r.req_type == REQ_LOCK) && !lock_hit) status_r <= STAT_FULL;
    end
    if (out_load) begin
      out_data_r.status        <= status_r;
      out_data_r.overlap_found <= found_r;
      out_data_r.cleared_count <= CNT_OUT_W'(cleared_r);
      out_data_r.occupancy     <= CNT_OUT_W'(used_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RLT_ASSERT_NOW(a_used_bound, 1'b1, used_r <= FULL_CNT, "occupancy above table size")
  `RLT_ASSERT_NEXT(a_accept_busy, accept, state_r != FSM_IDLE, "request taken but sequencer idle")
  `RLT_ASSERT_NOW(a_scan_write, wr_en && (state_r == FSM_SCAN), pend_r,
                  "entry write without read data")
  `RLT_ASSERT_NOW(a_cleared_bound, state_r == FSM_SCAN, cleared_r <= used_r,
                  "more entries cleared than held")
  `RLT_ASSERT_NEXT(a_full_lock, accept && (in_data.req_type == REQ_LOCK) && !zero_len &&
                   (used_r == FULL_CNT), state_r == FSM_DONE, "lock on full table scanned")

endmodule

`default_nettype wire
